[src/bsui_pkg.sv]
`timescale 1ns / 1ps

package bsui_pkg;

  localparam int SET_DEPTH = 16;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int ELEM_W = 32;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    CMD_CLR_A = 3'd0,
    CMD_CLR_B = 3'd1,
    CMD_APP_A = 3'd2,
    CMD_APP_B = 3'd3,
    CMD_UNION = 3'd4,
    CMD_INTER = 3'd5,
    CMD_EQUAL = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_SCAN,
    OP_FLUSH,
    OP_REPORT
  } op_t;

  typedef enum logic [1:0] {
    COND_ALL,
    COND_HIT,
    COND_MISS,
    COND_EQ
  } cond_t;

  // sel_b picks set B as the scanned or targeted set; the other set is searched.
  typedef struct packed {
    op_t   op;
    logic  sel_b;
    cond_t cond;
  } uword_t;

  localparam logic [PC_W-1:0] PC_CLR_A = 4'd0;
  localparam logic [PC_W-1:0] PC_CLR_B = 4'd1;
  localparam logic [PC_W-1:0] PC_APP_A = 4'd2;
  localparam logic [PC_W-1:0] PC_APP_B = 4'd3;
  localparam logic [PC_W-1:0] PC_UNION = 4'd4;
  localparam logic [PC_W-1:0] PC_INTER = 4'd7;
  localparam logic [PC_W-1:0] PC_EQUAL = 4'd9;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_REPORT, sel_b: 1'b0, cond: COND_ALL};
    unique case (pc)
      4'd0:    w = '{op: OP_CLEAR,  sel_b: 1'b0, cond: COND_ALL};
      4'd1:    w = '{op: OP_CLEAR,  sel_b: 1'b1, cond: COND_ALL};
      4'd2:    w = '{op: OP_APPEND, sel_b: 1'b0, cond: COND_ALL};
      4'd3:    w = '{op: OP_APPEND, sel_b: 1'b1, cond: COND_ALL};
      4'd4:    w = '{op: OP_SCAN,   sel_b: 1'b0, cond: COND_ALL};
      4'd5:    w = '{op: OP_SCAN,   sel_b: 1'b1, cond: COND_MISS};
      4'd6:    w = '{op: OP_FLUSH,  sel_b: 1'b0, cond: COND_ALL};
      4'd7:    w = '{op: OP_SCAN,   sel_b: 1'b0, cond: COND_HIT};
      4'd8:    w = '{op: OP_FLUSH,  sel_b: 1'b0, cond: COND_ALL};
      4'd9:    w = '{op: OP_SCAN,   sel_b: 1'b0, cond: COND_EQ};
      4'd10:   w = '{op: OP_REPORT, sel_b: 1'b0, cond: COND_ALL};
      default: w = '{op: OP_REPORT, sel_b: 1'b0, cond: COND_ALL};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input cmd_t cmd);
    logic [PC_W-1:0] pc;
    pc = PC_CLR_A;
    unique case (cmd)
      CMD_CLR_A: pc = PC_CLR_A;
      CMD_CLR_B: pc = PC_CLR_B;
      CMD_APP_A: pc = PC_APP_A;
      CMD_APP_B: pc = PC_APP_B;
      CMD_UNION: pc = PC_UNION;
      CMD_INTER: pc = PC_INTER;
      CMD_EQUAL: pc = PC_EQUAL;
      default:   pc = PC_CLR_A;
    endcase
    return pc;
  endfunction

endpackage

[src/bounded_set_union_intersection_core.sv]
`timescale 1ns / 1ps

// Two bounded sets A and B of signed 32-bit values, driven by a stream of requests.
// The slave channel takes one request: tuser carries the command (clear A, clear B,
// append A, append B, union, intersect, equal) and tdata carries the value to append.
// The master channel returns the results of that request, tlast on the final one.
// A clear or an append request registers its one result once the output register
// can take it. Union scans A and then B, intersect and equal scan A, one entry per
// cycle unless a found element waits on a stalled receiver, each entry searched
// against the other set in parallel, with one step after each scan and one final
// step for the last result. Results leave at most one element per cycle; a found
// element leaves when the next one is found or at the end. Request code seven is
// taken and ignored. The block takes one request at a time: s_axis_tready stays low
// until the last result of the current request is registered, so the next request
// can be taken in the cycle after that.
// Reset empties both sets and drops any result not yet taken. When the receiver
// stalls, the result holds in the output register and the scan waits until it can
// hand on its next element.
module bounded_set_union_intersection_core
  import bsui_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value [31:0]
  input  logic [2:0]             s_axis_tuser,   // cmd [2:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // element [31:0], is_equal [32], overflow [33]
  output logic                   m_axis_tuser,   // has_element [0]
  output logic                   m_axis_tlast    // last
);

  logic [ELEM_W-1:0] set_a [SET_DEPTH];
  logic [ELEM_W-1:0] set_b [SET_DEPTH];
  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt_b;

  logic              busy;
  logic [PC_W-1:0]   pc;
  logic [CNT_W-1:0]  idx;
  logic [ELEM_W-1:0] value_q;
  logic              eq;
  logic              pend_valid;
  logic [ELEM_W-1:0] pend_elem;

  logic              out_valid;
  logic [ELEM_W-1:0] out_elem;
  logic              out_has;
  logic              out_eq;
  logic              out_ovf;
  logic              out_last;

  uword_t            uw;
  logic [CNT_W-1:0]  src_cnt;
  logic [CNT_W-1:0]  oth_cnt;
  logic [CNT_W-1:0]  tgt_cnt;
  logic [ELEM_W-1:0] cand;
  logic              hit;
  logic              take;
  logic              scan_end;
  logic              can_emit;
  logic              in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign can_emit = !out_valid || m_axis_tready;

  always_comb begin
    uw = ucode(pc);
    src_cnt = uw.sel_b ? cnt_b : cnt_a;
    oth_cnt = uw.sel_b ? cnt_a : cnt_b;
    tgt_cnt = src_cnt;
    scan_end = (idx >= src_cnt);
    cand = uw.sel_b ? set_b[idx[IDX_W-1:0]] : set_a[idx[IDX_W-1:0]];
    hit = 1'b0;
    for (int k = 0; k < SET_DEPTH; k++) begin
      if ((CNT_W'(k) < oth_cnt) &&
          ((uw.sel_b ? set_a[k] : set_b[k]) == cand)) begin
        hit = 1'b1;
      end
    end
    take = 1'b0;
    unique case (uw.cond)
      COND_ALL:  take = 1'b1;
      COND_HIT:  take = hit;
      COND_MISS: take = !hit;
      COND_EQ:   take = 1'b0;
      default:   take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= '0;
      idx <= '0;
      cnt_a <= '0;
      cnt_b <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (!busy) begin
        if (in_accept && (s_axis_tuser <= 3'(CMD_EQUAL))) begin
          busy <= 1'b1;
          pc <= entry_pc(cmd_t'(s_axis_tuser));
          idx <= '0;
          pend_valid <= 1'b0;
          eq <= (cnt_a == cnt_b);
          value_q <= s_axis_tdata[ELEM_W-1:0];
        end
      end else begin
        unique case (uw.op)
          OP_CLEAR: begin
            if (can_emit) begin
              if (uw.sel_b) begin
                cnt_b <= '0;
              end else begin
                cnt_a <= '0;
              end
              out_valid <= 1'b1;
              out_elem <= '0;
              out_has <= 1'b0;
              out_eq <= 1'b0;
              out_ovf <= 1'b0;
              out_last <= 1'b1;
              busy <= 1'b0;
            end
          end
          OP_APPEND: begin
            if (can_emit) begin
              if (tgt_cnt < CNT_W'(SET_DEPTH)) begin
                if (uw.sel_b) begin
                  set_b[tgt_cnt[IDX_W-1:0]] <= value_q;
                  cnt_b <= cnt_b + 1'b1;
                end else begin
                  set_a[tgt_cnt[IDX_W-1:0]] <= value_q;
                  cnt_a <= cnt_a + 1'b1;
                end
                out_ovf <= 1'b0;
              end else begin
                out_ovf <= 1'b1;
              end
              out_valid <= 1'b1;
              out_elem <= '0;
              out_has <= 1'b0;
              out_eq <= 1'b0;
              out_last <= 1'b1;
              busy <= 1'b0;
            end
          end
          OP_SCAN: begin
            if (scan_end) begin
              pc <= pc + 1'b1;
              idx <= '0;
            end else if (!(take && pend_valid && !can_emit)) begin
              idx <= idx + 1'b1;
              if ((uw.cond == COND_EQ) && !hit) begin
                eq <= 1'b0;
              end
              if (take) begin
                pend_elem <= cand;
                pend_valid <= 1'b1;
                if (pend_valid) begin
                  out_valid <= 1'b1;
                  out_elem <= pend_elem;
                  out_has <= 1'b1;
                  out_eq <= 1'b0;
                  out_ovf <= 1'b0;
                  out_last <= 1'b0;
                end
              end
            end
          end
          OP_FLUSH: begin
            if (can_emit) begin
              out_valid <= 1'b1;
              out_elem <= pend_valid ? pend_elem : '0;
              out_has <= pend_valid;
              out_eq <= 1'b0;
              out_ovf <= 1'b0;
              out_last <= 1'b1;
              pend_valid <= 1'b0;
              busy <= 1'b0;
            end
          end
          OP_REPORT: begin
            if (can_emit) begin
              out_valid <= 1'b1;
              out_elem <= '0;
              out_has <= 1'b0;
              out_eq <= eq;
              out_ovf <= 1'b0;
              out_last <= 1'b1;
              busy <= 1'b0;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {(OUT_TDATA_W - ELEM_W - 2)'(0), out_ovf, out_eq, out_elem};
  assign m_axis_tuser = out_has;
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CNT_W'(SET_DEPTH)) && (cnt_b <= CNT_W'(SET_DEPTH)))
    else $error("set count exceeds depth");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_valid)
    else $error("pending element left over while idle");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_has && (out_ovf || out_eq)))
    else $error("element result carries an overflow or equality flag");

  a_unused_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (s_axis_tuser == 3'd7)) |=> !busy)
    else $error("unused command started work");

  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_ovf || out_eq)) |-> out_last)
    else $error("flag result not marked last");
`endif

endmodule
